/* sv/sra_pkg.sv */
// Package with the shared types and constants of the smoke ratio alarm detector.
`timescale 1ns / 1ps

package sra_pkg;

    localparam int SAMPLE_W = 10;
    localparam int RATIO_W  = 22;
    localparam int COUNT_W  = 16;
    localparam int FRAC_W   = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;
    localparam int DIV_STEPS  = RATIO_W;
    localparam int DIV_CNT_W  = 5;

    localparam logic [CFG_IDX_W-1:0] REG_BASELINE_A     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE_B     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_HIGH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_STEP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DRIFT_STEP     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_TARGET  = 3'd7;

    localparam logic [SAMPLE_W-1:0] RST_DROP_THRESHOLD = 10'd30;
    localparam logic [RATIO_W-1:0]  RST_RATIO_LOW      = 22'd6144;
    localparam logic [RATIO_W-1:0]  RST_RATIO_HIGH     = 22'd9830;
    localparam logic [RATIO_W-1:0]  RST_STABLE_STEP    = 22'd410;
    localparam logic [RATIO_W-1:0]  RST_DRIFT_STEP     = 22'd819;
    localparam logic [COUNT_W-1:0]  RST_STABLE_TARGET  = 16'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EVAL,
        ST_COMMIT
    } state_t;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_STABLE,
        CLS_DRIFT,
        CLS_CLEAR
    } change_cls_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic eval;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic qual;
        logic div_last;
        logic out_free;
    } ctrl_stat_t;

endpackage

/* sv/sra_ctrl.sv */
// Controller state machine that sequences load, division, evaluation and commit.
`timescale 1ns / 1ps

module sra_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  sra_pkg::ctrl_stat_t stat,
    output sra_pkg::ctrl_cmd_t  cmd
);
    import sra_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (!stat.qual)
                begin
                    state_next = ST_COMMIT;
                end
                else if (stat.div_last)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        cmd.load     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.eval     = 1'b0;
        cmd.commit   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = stat.qual;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            ST_COMMIT:
            begin
                cmd.commit = stat.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* sv/sra_datapath.sv */
// Datapath: configuration registers, restoring divider, counters and result register.
`timescale 1ns / 1ps

module sra_datapath #(
    parameter int unsigned DRIFT_TARGET = 40
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [sra_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sra_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic [sra_pkg::SAMPLE_W-1:0]          sample_a,
    input  logic [sra_pkg::SAMPLE_W-1:0]          sample_b,
    input  sra_pkg::ctrl_cmd_t                    cmd,
    output sra_pkg::ctrl_stat_t                   stat,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic                                  fire_alarm,
    output logic                                  qualified,
    output logic [sra_pkg::RATIO_W-1:0]           ratio_value,
    output logic [sra_pkg::COUNT_W-1:0]           stable_level,
    output logic [sra_pkg::COUNT_W-1:0]           drift_level
);
    import sra_pkg::*;

    localparam logic [COUNT_W-1:0] DRIFT_GOAL = COUNT_W'(DRIFT_TARGET);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

    logic [SAMPLE_W-1:0] baseline_a_reg;
    logic [SAMPLE_W-1:0] baseline_b_reg;
    logic [SAMPLE_W-1:0] drop_threshold_reg;
    logic [RATIO_W-1:0]  ratio_low_reg;
    logic [RATIO_W-1:0]  ratio_high_reg;
    logic [RATIO_W-1:0]  stable_step_reg;
    logic [RATIO_W-1:0]  drift_step_reg;
    logic [COUNT_W-1:0]  stable_target_reg;

    logic                qual_reg;
    logic                qual_next;
    logic [SAMPLE_W-1:0] den_reg;
    logic [SAMPLE_W-1:0] num_next;
    logic [SAMPLE_W-1:0] rem_reg;
    logic [SAMPLE_W-1:0] rem_next;
    logic [RATIO_W-1:0]  quo_reg;
    logic [RATIO_W-1:0]  quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SAMPLE_W:0]   rem_shift;
    logic [SAMPLE_W:0]   rem_diff;
    logic                rem_ge;

    logic                in_window;
    logic [RATIO_W-1:0]  ratio_delta;
    change_cls_t         cls_reg;
    change_cls_t         cls_next;

    logic [COUNT_W-1:0]  stable_count_reg;
    logic [COUNT_W-1:0]  stable_count_next;
    logic [COUNT_W-1:0]  drift_count_reg;
    logic [COUNT_W-1:0]  drift_count_next;
    logic [RATIO_W-1:0]  previous_ratio_reg;
    logic                alarm_latch_reg;
    logic                alarm_latch_next;
    logic [COUNT_W+1:0]  drift_sum;

    logic                m_tvalid_reg;
    logic                m_tvalid_next;
    logic                res_fire_reg;
    logic                res_qual_reg;
    logic [RATIO_W-1:0]  res_ratio_reg;
    logic [COUNT_W-1:0]  res_stable_reg;
    logic [COUNT_W-1:0]  res_drift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_a_reg     <= '0;
            baseline_b_reg     <= '0;
            drop_threshold_reg <= RST_DROP_THRESHOLD;
            ratio_low_reg      <= RST_RATIO_LOW;
            ratio_high_reg     <= RST_RATIO_HIGH;
            stable_step_reg    <= RST_STABLE_STEP;
            drift_step_reg     <= RST_DRIFT_STEP;
            stable_target_reg  <= RST_STABLE_TARGET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASELINE_A:     baseline_a_reg     <= cfg_data[SAMPLE_W-1:0];
                REG_BASELINE_B:     baseline_b_reg     <= cfg_data[SAMPLE_W-1:0];
                REG_DROP_THRESHOLD: drop_threshold_reg <= cfg_data[SAMPLE_W-1:0];
                REG_RATIO_LOW:      ratio_low_reg      <= cfg_data[RATIO_W-1:0];
                REG_RATIO_HIGH:     ratio_high_reg     <= cfg_data[RATIO_W-1:0];
                REG_STABLE_STEP:    stable_step_reg    <= cfg_data[RATIO_W-1:0];
                REG_DRIFT_STEP:     drift_step_reg     <= cfg_data[RATIO_W-1:0];
                REG_STABLE_TARGET:  stable_target_reg  <= cfg_data[COUNT_W-1:0];
            endcase
        end
    end

    // Qualification and the operands of the division are formed as the sample is taken.
    always_comb
    begin
        num_next  = baseline_a_reg - sample_a;
        qual_next = (sample_a < baseline_a_reg) && (sample_b < baseline_b_reg)
                    && (num_next > drop_threshold_reg);
    end

    // One restoring step per cycle; the numerator shifted left by the fraction width
    // enters the quotient register and is consumed from the top.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[RATIO_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        rem_ge    = rem_shift >= {1'b0, den_reg};
        rem_next  = rem_ge ? rem_diff[SAMPLE_W-1:0] : rem_shift[SAMPLE_W-1:0];
        quo_next  = {quo_reg[RATIO_W-2:0], rem_ge};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            den_reg <= baseline_b_reg - sample_b;
            rem_reg <= '0;
            quo_reg <= {num_next, {FRAC_W{1'b0}}};
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        in_window   = (quo_reg > ratio_low_reg) && (quo_reg < ratio_high_reg);
        ratio_delta = (quo_reg >= previous_ratio_reg) ? quo_reg - previous_ratio_reg
                                                      : previous_ratio_reg - quo_reg;
        if (!in_window)
        begin
            cls_next = CLS_NONE;
        end
        else if (ratio_delta < stable_step_reg)
        begin
            cls_next = CLS_STABLE;
        end
        else if (ratio_delta < drift_step_reg)
        begin
            cls_next = CLS_DRIFT;
        end
        else
        begin
            cls_next = CLS_CLEAR;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            qual_reg <= qual_next;
        end
        if (cmd.eval)
        begin
            cls_reg <= cls_next;
        end
    end

    always_comb
    begin
        drift_sum         = {2'b0, stable_count_reg} + {2'b0, drift_count_reg} + 1'b1;
        stable_count_next = stable_count_reg;
        drift_count_next  = drift_count_reg;
        case (cls_reg)
            CLS_STABLE:
            begin
                if (stable_count_reg != COUNT_MAX)
                begin
                    stable_count_next = stable_count_reg + 1'b1;
                end
            end
            CLS_DRIFT:
            begin
                drift_count_next  = (drift_sum > {2'b0, COUNT_MAX}) ? COUNT_MAX
                                                                    : drift_sum[COUNT_W-1:0];
                stable_count_next = '0;
            end
            CLS_CLEAR:
            begin
                stable_count_next = '0;
                drift_count_next  = '0;
            end
            default:
            begin
                stable_count_next = stable_count_reg;
            end
        endcase
        alarm_latch_next = alarm_latch_reg || (stable_count_next == stable_target_reg)
                           || (drift_count_next == DRIFT_GOAL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_count_reg   <= '0;
            drift_count_reg    <= '0;
            previous_ratio_reg <= '0;
            alarm_latch_reg    <= 1'b0;
        end
        else if (cmd.commit && qual_reg)
        begin
            stable_count_reg   <= stable_count_next;
            drift_count_reg    <= drift_count_next;
            previous_ratio_reg <= quo_reg;
            alarm_latch_reg    <= alarm_latch_next;
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.commit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_qual_reg <= qual_reg;
            if (qual_reg)
            begin
                res_fire_reg   <= alarm_latch_next;
                res_ratio_reg  <= quo_reg;
                res_stable_reg <= stable_count_next;
                res_drift_reg  <= drift_count_next;
            end
            else
            begin
                res_fire_reg   <= alarm_latch_reg;
                res_ratio_reg  <= '0;
                res_stable_reg <= stable_count_reg;
                res_drift_reg  <= drift_count_reg;
            end
        end
    end

    assign stat.qual     = qual_reg;
    assign stat.div_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign stat.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid     = m_tvalid_reg;
    assign fire_alarm   = res_fire_reg;
    assign qualified    = res_qual_reg;
    assign ratio_value  = res_ratio_reg;
    assign stable_level = res_stable_reg;
    assign drift_level  = res_drift_reg;

endmodule

/* sv/smoke_ratio_alarm_detector.sv */
// Top level of the smoke ratio alarm detector.
//
// The slave stream carries one tick per transaction: sample_a in s_tdata[9:0] and
// sample_b in s_tdata[19:10]. The master stream returns one result per tick.
// Thresholds, baselines, ratio window, steps and the stable target are written
// through cfg_we, cfg_index and cfg_data; the user must write them only while the
// block is idle, and the block itself does not enforce it. A qualified tick forms
// the Q10.12 drop ratio in a restoring divider that resolves one quotient bit per
// cycle; the evaluation step then classifies the ratio change and the commit step
// updates the counters. An unqualified tick performs no division steps and no
// evaluation before the commit step. m_tvalid is registered and rises after the
// commit step; s_tready is high only while the sequencer is idle, so the next tick
// is taken only once the previous one has been committed.
// The result register lets a new tick be taken while the previous result still
// waits; if the receiver stalls, the sequencer holds in its commit step until the
// result register is free, and no state changes until then.
// Reset clears the counters, the previous ratio and the alarm latch, and loads
// the register defaults. The alarm latch clears only by reset.
`timescale 1ns / 1ps

module smoke_ratio_alarm_detector #(
    parameter int unsigned DRIFT_TARGET = 40
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sra_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sra_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: sample_a[9:0], sample_b[19:10], zero padding.
    input  logic [sra_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0: fire_alarm[0], qualified[1], ratio_value[23:2],
    // stable_level[39:24], drift_level[55:40].
    output logic [sra_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import sra_pkg::*;

    ctrl_cmd_t            cmd;
    ctrl_stat_t           stat;
    logic                 fire_alarm;
    logic                 qualified;
    logic [RATIO_W-1:0]   ratio_value;
    logic [COUNT_W-1:0]   stable_level;
    logic [COUNT_W-1:0]   drift_level;

    sra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sra_datapath #(
        .DRIFT_TARGET (DRIFT_TARGET)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_a     (s_tdata[SAMPLE_W-1:0]),
        .sample_b     (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .cmd          (cmd),
        .stat         (stat),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .fire_alarm   (fire_alarm),
        .qualified    (qualified),
        .ratio_value  (ratio_value),
        .stable_level (stable_level),
        .drift_level  (drift_level)
    );

    assign m_tdata = {drift_level, stable_level, ratio_value, qualified, fire_alarm};

endmodule
